[sv/itoa_pkg.sv]
// Package for the signed integer to decimal ASCII converter.
// Holds widths, character codes and the pipeline stage record.
// No dependencies.
package itoa_pkg;

  // Width of the signed input value (8 to 64)
  localparam int INPUT_WIDTH    = 32;
  // Stream data width: the value padded up to whole bytes
  localparam int S_TDATA_W      = ((INPUT_WIDTH + 7) / 8) * 8;
  // Decimal digits kept; an upper bound on the digits of any INPUT_WIDTH-bit magnitude
  localparam int DIGITS         = (INPUT_WIDTH * 31) / 100 + 1;
  localparam int BCD_W          = DIGITS * 4;
  localparam int IDX_W          = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  // Shift-and-add-3 steps per pipeline stage
  localparam int BITS_PER_STAGE = 8;
  localparam int DABBLE_STAGES  = (INPUT_WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  // Entry register, negate stage, then the conversion stages
  localparam int NSTAGE         = DABBLE_STAGES + 2;

  localparam int CHAR_W = 8;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  // One item as it moves down the pipeline
  typedef struct packed {
    logic                   neg;
    logic [INPUT_WIDTH-1:0] bin;
    logic [BCD_W-1:0]       bcd;
  } stage_t;

endpackage

[sv/signed_int_to_decimal_ascii.sv]
// Signed integer to decimal ASCII converter, top level.
// Pipelined binary-to-BCD conversion followed by a character serialiser.
// Depends on itoa_pkg.
//
// Usage:
//   Slave channel: one signed value per transfer on s_axis_tdata.
//   Master channel: one ASCII character per transfer on m_axis_tdata,
//   most significant digit first, '-' first for a negative value, and
//   a single trailing space that carries m_axis_tlast.
// Pipeline: a value accepted on an idle block passes an entry register,
//   a negate stage and four shift-and-add-3 stages of eight bits each,
//   then the serialiser register, before its first character shows.
// Throughput: the master side moves one character per cycle while
//   m_axis_tready is high, so a value occupies the output for its text
//   length, 2 to 12 characters at 32 bits (digits + sign + space). The
//   serialiser takes the next value in the cycle its trailing space is
//   transferred, so texts follow with no gap; up to NSTAGE more wait in the pipeline.
// Reset: rst is synchronous, active high; it empties the pipeline and
//   the serialiser. Nothing else is kept between values.
// Stall: while m_axis_tready is low the current character holds, the
//   pipeline fills up and s_axis_tready drops once every stage is full.
module signed_int_to_decimal_ascii (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [itoa_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [INPUT_WIDTH-1:0] value
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [itoa_pkg::CHAR_W-1:0]    m_axis_tdata,  // [7:0] character
  output logic                           m_axis_tlast
);
  import itoa_pkg::*;

  localparam logic [1:0] SER_IDLE  = 2'd0;
  localparam logic [1:0] SER_SIGN  = 2'd1;
  localparam logic [1:0] SER_DIGIT = 2'd2;
  localparam logic [1:0] SER_SPACE = 2'd3;

  // One shift-and-add-3 step: bump digits of 5 or more, then shift a bit in
  function automatic stage_t dabble_bit(input stage_t s);
    stage_t r;
    r = s;
    for (int d = 0; d < DIGITS; d++) begin
      if (r.bcd[d*4 +: 4] >= 4'd5) begin
        r.bcd[d*4 +: 4] = r.bcd[d*4 +: 4] + 4'd3;
      end
    end
    {r.bcd, r.bin} = {r.bcd, r.bin} << 1;
    return r;
  endfunction

  // Highest non-zero digit, or the lowest digit for zero
  function automatic logic [IDX_W-1:0] lead_index(input logic [BCD_W-1:0] bcd);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd[d*4 +: 4] != 4'd0) begin
        idx = IDX_W'(d);
      end
    end
    return idx;
  endfunction

  logic [NSTAGE:0]   stage_ready;
  logic [NSTAGE-1:0] st_valid;
  stage_t            st      [NSTAGE];
  stage_t            st_next [NSTAGE];

  logic [1:0]        ser_state;
  logic              ser_neg;
  logic [IDX_W-1:0]  ser_idx;
  logic [BCD_W-1:0]  ser_bcd;
  logic              load_ok;
  logic              load;

  // Back-pressure: a stage can take a new item when empty or moving on
  always_comb begin
    stage_ready[NSTAGE] = load_ok;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      stage_ready[k] = !st_valid[k] || stage_ready[k+1];
    end
  end

  assign s_axis_tready = stage_ready[0];

  // Stage logic and registers
  for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
    if (k == 0) begin : g_entry
      // Entry register: capture value and sign
      always_comb begin
        st_next[k].neg = s_axis_tdata[INPUT_WIDTH-1];
        st_next[k].bin = s_axis_tdata[INPUT_WIDTH-1:0];
        st_next[k].bcd = '0;
      end
    end else if (k == 1) begin : g_negate
      // Magnitude; the most negative value maps onto 2^(INPUT_WIDTH-1)
      always_comb begin
        st_next[k]     = st[k-1];
        st_next[k].bin = st[k-1].neg ? (~st[k-1].bin + INPUT_WIDTH'(1)) : st[k-1].bin;
      end
    end else begin : g_dabble
      localparam int FIRST = (k - 2) * BITS_PER_STAGE;
      localparam int NB    = (INPUT_WIDTH - FIRST < BITS_PER_STAGE) ?
                             (INPUT_WIDTH - FIRST) : BITS_PER_STAGE;
      // NB shift-and-add-3 steps
      always_comb begin
        st_next[k] = st[k-1];
        for (int b = 0; b < NB; b++) begin
          st_next[k] = dabble_bit(st_next[k]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k] <= 1'b0;
      end else if (stage_ready[k]) begin
        st_valid[k] <= (k == 0) ? s_axis_tvalid : st_valid[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (stage_ready[k]) begin
        st[k] <= st_next[k];
      end
    end
  end

  // Serialiser takes a new item when idle or as its trailing space leaves
  assign load_ok = (ser_state == SER_IDLE) || ((ser_state == SER_SPACE) && m_axis_tready);
  assign load    = load_ok && st_valid[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_state <= SER_IDLE;
    end else if (load) begin
      ser_state <= st[NSTAGE-1].neg ? SER_SIGN : SER_DIGIT;
    end else if (m_axis_tready) begin
      unique case (ser_state)
        SER_IDLE:  ser_state <= SER_IDLE;
        SER_SIGN:  ser_state <= SER_DIGIT;
        SER_DIGIT: ser_state <= (ser_idx == '0) ? SER_SPACE : SER_DIGIT;
        SER_SPACE: ser_state <= SER_IDLE;
      endcase
    end
  end

  // Serialiser payload: digits and the digit pointer
  always_ff @(posedge clk) begin
    if (load) begin
      ser_neg <= st[NSTAGE-1].neg;
      ser_bcd <= st[NSTAGE-1].bcd;
      ser_idx <= lead_index(st[NSTAGE-1].bcd);
    end else if (m_axis_tready && (ser_state == SER_DIGIT) && (ser_idx != '0)) begin
      ser_idx <= ser_idx - IDX_W'(1);
    end
  end

  // Output character from the serialiser state
  always_comb begin
    m_axis_tvalid = (ser_state != SER_IDLE);
    m_axis_tlast  = (ser_state == SER_SPACE);
    unique case (ser_state)
      SER_IDLE:  m_axis_tdata = ser_neg ? CHAR_MINUS : CHAR_SPACE;
      SER_SIGN:  m_axis_tdata = CHAR_MINUS;
      SER_DIGIT: m_axis_tdata = CHAR_ZERO + {4'd0, ser_bcd[ser_idx*4 +: 4]};
      SER_SPACE: m_axis_tdata = CHAR_SPACE;
    endcase
  end

endmodule

[sv/itoa_checker.sv]
// Port-level checker for the signed integer to decimal ASCII converter.
// Bound to the top level below. Depends on itoa_pkg.
module itoa_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [itoa_pkg::CHAR_W-1:0]    m_axis_tdata,
  input logic                           m_axis_tlast
);
  import itoa_pkg::*;

  // Nothing on the output right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // The ending character is always the space
  a_last_space: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == CHAR_SPACE))
    else $error("tlast on a character other than space");

  // A space appears only as the ending character
  a_space_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata != CHAR_SPACE))
    else $error("space without tlast");

  // A minus sign is followed at once by a digit
  a_minus_digit: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && (m_axis_tdata == CHAR_MINUS)) |=>
    (m_axis_tvalid && (m_axis_tdata >= CHAR_ZERO) && (m_axis_tdata <= CHAR_NINE)))
    else $error("minus sign not followed by a digit");

  // Stalled character holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
    (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output changed while stalled");

endmodule

bind signed_int_to_decimal_ascii itoa_checker u_itoa_checker (.*);

[test/signed_int_to_decimal_ascii_tb.sv]
// Testbench for signed_int_to_decimal_ascii: drives signed values, predicts each decimal
// text and checks every character and its tlast, under random idling on both sides.
// Depends on itoa_pkg and the signed_int_to_decimal_ascii RTL.
module signed_int_to_decimal_ascii_tb;
  import itoa_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 2 * NSTAGE + 16;
  localparam int RANDOM_VALUES  = 112;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  // Holds the characters still owed by the block, oldest first
  class text_scoreboard;
    text_char_t pending_text[$];
    int         errors = 0;

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void push_char(logic [CHAR_W-1:0] code, logic last);
      text_char_t c;
      c.code = code;
      c.last = last;
      pending_text.push_back(c);
    endfunction

    // Decimal text of one accepted value: optional '-', digits MSD first, one space
    function void note_value(logic [INPUT_WIDTH-1:0] value);
      logic [INPUT_WIDTH:0] magnitude;
      logic [3:0]           digits[$];
      logic                 negative;
      negative  = value[INPUT_WIDTH-1];
      // one bit wider so the most negative value keeps its full magnitude
      magnitude = negative ? ({1'b0, ~value} + 1'b1) : {1'b0, value};
      do begin
        digits.push_front(4'(magnitude % 10));
        magnitude = magnitude / 10;
      end while (magnitude != 0);
      if (negative) push_char(CHAR_MINUS, 1'b0);
      foreach (digits[i]) push_char(CHAR_ZERO + CHAR_W'(digits[i]), 1'b0);
      push_char(CHAR_SPACE, 1'b1);
    endfunction

    task check_char(logic [CHAR_W-1:0] code, logic last);
      text_char_t want;
      if (pending_text.size() == 0) begin
        report($sformatf("character 0x%02h last %0b with nothing outstanding", code, last));
      end else begin
        want = pending_text.pop_front();
        if (code !== want.code)
          report($sformatf("character 0x%02h, predicted 0x%02h", code, want.code));
        if (last !== want.last)
          report($sformatf("tlast %0b, predicted %0b on 0x%02h", last, want.last, want.code));
      end
    endtask

    function int outstanding();
      return pending_text.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [CHAR_W-1:0]    m_axis_tdata;
  logic                 m_axis_tlast;

  text_scoreboard score = new();
  int             ready_left = 0;
  int             ready_pick;
  int             idle_cycles = 0;

  signed_int_to_decimal_ascii dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [INPUT_WIDTH-1:0] value
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] character
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: runs of ready and stalls, mostly short, some long, some long free stretches
  always @(posedge clk) begin
    if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 45) begin
        m_axis_tready <= 1'b1;
        ready_left    <= $urandom_range(0, 4);
      end else if (ready_pick < 55) begin
        m_axis_tready <= 1'b1;
        ready_left    <= $urandom_range(30, 150);
      end else if (ready_pick < 92) begin
        m_axis_tready <= 1'b0;
        ready_left    <= $urandom_range(0, 3);
      end else begin
        m_axis_tready <= 1'b0;
        ready_left    <= $urandom_range(10, 60);
      end
    end
  end

  // Transfer monitor: values sampled on the accepting edge, characters checked in order
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) score.note_value(s_axis_tdata[INPUT_WIDTH-1:0]);
      if (m_axis_tvalid && m_axis_tready) score.check_char(m_axis_tdata, m_axis_tlast);
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Mix of full-width words, values of a random digit count and powers of ten +/- 1
  function automatic logic [INPUT_WIDTH-1:0] random_value();
    int          r;
    int unsigned digits;
    longint      span;
    longint      mag;
    r = $urandom_range(0, 99);
    if (r < 35) return INPUT_WIDTH'($urandom());
    if (r < 75) begin
      digits = $urandom_range(1, 10);
      span   = 1;
      repeat (digits) span = span * 10;
      if (span - 1 > 64'h7FFF_FFFF) span = 64'h8000_0000;
      mag = $urandom_range(0, 32'(span - 1));
    end else begin
      span = 1;
      repeat ($urandom_range(0, 9)) span = span * 10;
      mag = span + $urandom_range(0, 2) - 1;
    end
    return $urandom_range(0, 1) ? INPUT_WIDTH'(-mag) : INPUT_WIDTH'(mag);
  endfunction

  // Presents one value and returns on the edge that accepts it
  task automatic send_value(input logic [INPUT_WIDTH-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'(value);
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  initial begin
    logic [INPUT_WIDTH-1:0] corner_values[$];
    corner_values = '{
      32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
      32'd999999999, -32'sd999999999, 32'h5555_5555, 32'hAAAA_AAAA,
      -32'sd5, 32'd123456789
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // corner cases: zero, extremes, most negative, digit-count boundaries
    foreach (corner_values[i]) send_value(corner_values[i]);
    repeat (RANDOM_VALUES) send_value(random_value());
    s_axis_tvalid <= 1'b0;

    // let the monitor note the last value
    @(posedge clk);
    while (score.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if ((score.errors == 0) && (score.outstanding() == 0))
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
